[design/rc4ske_pkg.sv]
// rc4ske_pkg: payload types, permuted-choice tables and helper functions
// for the rc4 seeded key schedule expander
// no dependencies
package rc4ske_pkg;

	typedef struct packed {
		logic [7:0] seed_byte_0;
		logic [7:0] seed_byte_1;
		logic [7:0] seed_byte_2;
		logic [7:0] seed_byte_3;
		logic [7:0] seed_byte_4;
	} seed_t;

	typedef struct packed {
		logic [63:0] random_word;
		logic        last_word;
	} result_t;

	typedef logic [27:0] half_t;

	localparam int PERM_DEPTH = 256;
	localparam int MAX_ROUNDS = 22;
	localparam int ROUND_W    = 5;
	localparam int BUF_W      = 112;
	localparam int CNT_W      = 7;

	// key bit taken by each of the 56 outputs of the initial key selection
	localparam logic [5:0] PC1_TAB [56] = '{
		6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,  6'd0,
		6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,
		6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,
		6'd59, 6'd51, 6'd43, 6'd35, 6'd62, 6'd54, 6'd46, 6'd38,
		6'd30, 6'd22, 6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37,
		6'd29, 6'd21, 6'd13, 6'd5,  6'd60, 6'd52, 6'd44, 6'd36,
		6'd28, 6'd20, 6'd12, 6'd4,  6'd27, 6'd19, 6'd11, 6'd3
	};

	// half element taken by each of the 48 outputs of the round compression
	localparam logic [5:0] PC2_TAB [48] = '{
		6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27,
		6'd14, 6'd5,  6'd20, 6'd9,  6'd22, 6'd18, 6'd11, 6'd3,
		6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
		6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39,
		6'd50, 6'd44, 6'd32, 6'd47, 6'd43, 6'd48, 6'd38, 6'd55,
		6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31
	};

	// bit r set where round r rotates by one, else by two
	localparam logic [MAX_ROUNDS-1:0] SHIFT_ONE = 22'b0000111000000100000011;

	// element n of the 56-bit pair sits at bit 55-n (left half first)
	function automatic logic [55:0] pc1(input logic [63:0] key);
		logic [55:0] cd;
		cd = '0;
		for (int n = 0; n < 56; n++) begin
			cd[55-n] = key[PC1_TAB[n]];
		end
		return cd;
	endfunction

	// earliest output bit at bit 47
	function automatic logic [47:0] pc2(input logic [55:0] cd);
		logic [47:0] bits;
		bits = '0;
		for (int n = 0; n < 48; n++) begin
			bits[47-n] = cd[6'd55 - PC2_TAB[n]];
		end
		return bits;
	endfunction

	function automatic half_t rot28(input half_t h, input logic by_one);
		return by_one ? {h[26:0], h[27]} : {h[25:0], h[27:26]};
	endfunction

	function automatic logic shift_is_one(input logic [ROUND_W-1:0] rnd);
		return (rnd < ROUND_W'(MAX_ROUNDS)) && SHIFT_ONE[rnd];
	endfunction

endpackage

[design/rc4_seeded_key_schedule_expander_core.sv]
// rc4_seeded_key_schedule_expander_core: top level, rc4 key scheduling and
// keystream on a 256 x 8 ram, then des-style key expansion into words
// depends on rc4ske_pkg and rc4ske_ram
//
// A transaction is taken when start is high and busy is low; busy stays high
// until the last word has been issued. The OUT_BITS result comes out as
// ceil(OUT_BITS/64) words, one per strobe cycle, earliest bit in the msb, with
// last_word set on the final one; strobes are not spaced evenly and the
// receiver must take each one as it comes. A transaction loads the identity
// permutation into the ram, runs the key scheduling swaps through states K_RD,
// K_J, K_WN and K_WJ and eight keystream bytes through states G_RI to G_T, the
// steps set by the single read and single write port of the permutation ram,
// then runs expansion rounds, issuing a word whenever enough bits are buffered.
module rc4_seeded_key_schedule_expander_core #(
	parameter int OUT_BITS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rc4ske_pkg::seed_t  seed,
	output logic               strobe,
	output rc4ske_pkg::result_t result
);

	localparam int WORDS  = (OUT_BITS + 63) / 64;
	localparam int LAST_N = OUT_BITS - 64 * (WORDS - 1);
	localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [63:0] LAST_MASK = ~64'd0 << (64 - LAST_N);
	localparam logic [63:0] LAST_BIT  = 64'd1 << (64 - LAST_N);

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT,
		ST_K_RD, ST_K_J, ST_K_WN, ST_K_WJ,
		ST_G_RI, ST_G_RJ, ST_G_WI, ST_G_WJ, ST_G_RT, ST_G_T,
		ST_PC1, ST_OUT
	} state_t;

	state_t                         state_q;
	logic [7:0]                     n_q;
	logic [7:0]                     j_q;
	logic [2:0]                     m_q;
	logic [2:0]                     k_q;
	logic [7:0]                     si_q;
	logic [7:0]                     sj_q;
	logic [63:0]                    key_q;
	rc4ske_pkg::seed_t              seed_q;
	rc4ske_pkg::half_t              left_q;
	rc4ske_pkg::half_t              right_q;
	logic [rc4ske_pkg::ROUND_W-1:0] rnd_q;
	logic [rc4ske_pkg::BUF_W-1:0]   buf_q;
	logic [rc4ske_pkg::CNT_W-1:0]   cnt_q;
	logic [WIDX_W-1:0]              widx_q;

	logic       ram_we;
	logic [7:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic [7:0] ram_raddr;
	logic [7:0] ram_rdata;

	logic [7:0] seed_sel;
	logic [7:0] j_ksa;
	logic [7:0] j_gen;

	rc4ske_pkg::half_t            left_rot;
	rc4ske_pkg::half_t            right_rot;
	logic [47:0]                  round_bits;
	logic [rc4ske_pkg::BUF_W-1:0] buf_app;
	logic                         is_last;
	logic                         word_ready;
	logic [63:0]                  word;

	rc4ske_ram #(
		.WIDTH(8),
		.DEPTH(rc4ske_pkg::PERM_DEPTH)
	) u_perm (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		case (m_q)
			3'd0:    seed_sel = seed_q.seed_byte_0;
			3'd1:    seed_sel = seed_q.seed_byte_1;
			3'd2:    seed_sel = seed_q.seed_byte_2;
			3'd3:    seed_sel = seed_q.seed_byte_3;
			default: seed_sel = seed_q.seed_byte_4;
		endcase
	end

	assign j_ksa = j_q + ram_rdata + seed_sel;
	assign j_gen = j_q + ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = n_q;
		ram_wdata = ram_rdata;
		ram_raddr = n_q;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = n_q;
			end
			ST_K_J:  ram_raddr = j_ksa;
			ST_G_RJ: ram_raddr = j_gen;
			ST_K_WN, ST_G_WI: ram_we = 1'b1;
			ST_K_WJ, ST_G_WJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			ST_G_RT: ram_raddr = si_q + sj_q;
			default: ;
		endcase
	end

	// one expansion round: rotate both halves, then compress to 48 bits
	always_comb begin
		left_rot   = rc4ske_pkg::rot28(left_q, rc4ske_pkg::shift_is_one(rnd_q));
		right_rot  = rc4ske_pkg::rot28(right_q, rc4ske_pkg::shift_is_one(rnd_q));
		round_bits = rc4ske_pkg::pc2({left_rot, right_rot});
		buf_app    = buf_q | ({round_bits, 64'd0} >> cnt_q);
	end

	always_comb begin
		is_last    = (widx_q == WIDX_W'(WORDS - 1));
		word_ready = is_last ? (cnt_q >= rc4ske_pkg::CNT_W'(LAST_N))
		                     : (cnt_q >= rc4ske_pkg::CNT_W'(64));
		word = buf_q[rc4ske_pkg::BUF_W-1 -: 64];
		if (is_last) begin
			word = (word & LAST_MASK) | LAST_BIT;
		end
		if (widx_q == '0) begin
			word[63] = 1'b1;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
			rnd_q   <= '0;
			cnt_q   <= '0;
			widx_q  <= '0;
			strobe  <= 1'b0;
			result  <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'd255) begin
						m_q     <= '0;
						state_q <= ST_K_RD;
					end
				end
				ST_K_RD: state_q <= ST_K_J;
				ST_K_J:  state_q <= ST_K_WN;
				ST_K_WN: state_q <= ST_K_WJ;
				ST_K_WJ: begin
					m_q <= (m_q == 3'd4) ? 3'd0 : m_q + 3'd1;
					if (n_q == 8'd255) begin
						n_q     <= 8'd1;
						k_q     <= '0;
						state_q <= ST_G_RI;
					end else begin
						n_q     <= n_q + 8'd1;
						state_q <= ST_K_RD;
					end
				end
				ST_G_RI: state_q <= ST_G_RJ;
				ST_G_RJ: state_q <= ST_G_WI;
				ST_G_WI: state_q <= ST_G_WJ;
				ST_G_WJ: state_q <= ST_G_RT;
				ST_G_RT: state_q <= ST_G_T;
				ST_G_T: begin
					n_q <= n_q + 8'd1;
					k_q <= k_q + 3'd1;
					state_q <= (k_q == 3'd7) ? ST_PC1 : ST_G_RI;
				end
				ST_PC1: begin
					rnd_q   <= '0;
					cnt_q   <= '0;
					widx_q  <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (word_ready) begin
						strobe             <= 1'b1;
						result.random_word <= word;
						result.last_word   <= is_last;
						cnt_q  <= cnt_q - rc4ske_pkg::CNT_W'(64);
						widx_q <= widx_q + WIDX_W'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + rc4ske_pkg::CNT_W'(48);
						rnd_q <= rnd_q + rc4ske_pkg::ROUND_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					seed_q <= seed;
				end
			end
			ST_K_RD: begin
				if (n_q == 8'd0) begin
					j_q <= '0;
				end
			end
			ST_K_J: begin
				si_q <= ram_rdata;
				j_q  <= j_ksa;
			end
			ST_K_WN: sj_q <= ram_rdata;
			ST_K_WJ: begin
				if (n_q == 8'd255) begin
					j_q <= '0;
				end
			end
			ST_G_RJ: begin
				si_q <= ram_rdata;
				j_q  <= j_gen;
			end
			ST_G_WI: sj_q <= ram_rdata;
			ST_G_T:  key_q <= {ram_rdata, key_q[63:8]};
			ST_PC1: begin
				{left_q, right_q} <= rc4ske_pkg::pc1(key_q);
				buf_q <= '0;
			end
			ST_OUT: begin
				if (word_ready) begin
					buf_q <= buf_q << 64;
				end else begin
					left_q  <= left_rot;
					right_q <= right_rot;
					buf_q   <= buf_app;
				end
			end
			default: ;
		endcase
	end

endmodule

[design/rc4ske_ram.sv]
// rc4ske_ram: generic simple dual-port ram, one write port and one
// registered read port; no dependencies
module rc4ske_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
